>>> rtl/core/cce_pkg.sv
// ----------------------------------------------------------------------------
// cce_pkg
// Shared types, codes and helper functions of the cheat compare/write engine.
// ----------------------------------------------------------------------------
`default_nettype none

package cce_pkg;

   // Table geometry
   localparam int ENTRY_COUNT = 64;
   localparam int SLOT_W      = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

   // Statistic counters
   localparam int CNT_COUNT = 8;
   localparam int CNT_SEL_W = 3;

   localparam logic [CNT_SEL_W-1:0] CNT_DISABLED = 3'd0;
   localparam logic [CNT_SEL_W-1:0] CNT_ONCE     = 3'd1;
   localparam logic [CNT_SEL_W-1:0] CNT_ATTEMPT  = 3'd2;
   localparam logic [CNT_SEL_W-1:0] CNT_READFAIL = 3'd3;
   localparam logic [CNT_SEL_W-1:0] CNT_CMPMISS  = 3'd4;
   localparam logic [CNT_SEL_W-1:0] CNT_WRFAIL   = 3'd5;
   localparam logic [CNT_SEL_W-1:0] CNT_APONCE   = 3'd6;
   localparam logic [CNT_SEL_W-1:0] CNT_APPLIED  = 3'd7;

   // Access width codes
   localparam logic [1:0] WIDTH_BYTE = 2'd0;
   localparam logic [1:0] WIDTH_HALF = 2'd1;
   localparam logic [1:0] WIDTH_WORD = 2'd2;

   typedef enum logic [1:0] {
      OP_LOAD      = 2'd0,
      OP_APPLY     = 2'd1,
      OP_READ_CNT  = 2'd2,
      OP_CLEAR_CNT = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      OUT_DISABLED  = 4'd0,
      OUT_ONCE_DONE = 4'd1,
      OUT_READ_FAIL = 4'd2,
      OUT_CMP_MISS  = 4'd3,
      OUT_WR_FAIL   = 4'd4,
      OUT_APPLIED   = 4'd5,
      OUT_LOADED    = 4'd6,
      OUT_REJECTED  = 4'd7,
      OUT_OTHER     = 4'd8
   } outcome_type;

   // Request payload
   typedef struct packed {
      logic [1:0]  op;
      logic [5:0]  index;
      logic        enabled;
      logic        once;
      logic [1:0]  width_code;
      logic [31:0] address;
      logic [31:0] value;
      logic        has_compare;
      logic [31:0] compare_value;
      logic [31:0] read_data;
      logic        read_ok;
      logic        write_ok;
   } req_type;

   // Response payload
   typedef struct packed {
      logic [3:0]  outcome;
      logic        write_request;
      logic [31:0] write_address;
      logic [31:0] write_data;
      logic [2:0]  write_size;
      logic [31:0] counter_value;
   } rsp_type;

   // One stored table entry (100 bits)
   typedef struct packed {
      logic        once;
      logic [1:0]  width_code;
      logic [31:0] address;
      logic [31:0] value;
      logic        has_compare;
      logic [31:0] compare_value;
   } entry_type;

   // Request as held between the front stage and the evaluation stage
   typedef struct packed {
      logic        valid;
      op_type      op;
      logic [5:0]  index;
      logic        in_range;
      logic        load_ok;
      logic [31:0] read_data;
      logic        read_ok;
      logic        write_ok;
   } stage_type;

   // Flag update from an accepted load
   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] slot;
      logic              enabled;
   } flag_load_type;

   // Counter update from the evaluation stage
   typedef struct packed {
      logic [CNT_COUNT-1:0] inc;
      logic                 clear;
   } stat_event_type;

   function automatic logic [31:0] width_mask(input logic [1:0] code);
      logic [31:0] mask;
      case (code)
         WIDTH_BYTE: mask = 32'h0000_00ff;
         WIDTH_HALF: mask = 32'h0000_ffff;
         default:    mask = 32'hffff_ffff;
      endcase
      return mask;
   endfunction

   function automatic logic [2:0] width_bytes(input logic [1:0] code);
      logic [2:0] nb;
      case (code)
         WIDTH_BYTE: nb = 3'd1;
         WIDTH_HALF: nb = 3'd2;
         WIDTH_WORD: nb = 3'd4;
         default:    nb = 3'd0;
      endcase
      return nb;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/cce_front.sv
// ----------------------------------------------------------------------------
// cce_front
// Input stage: checks load requests, writes and reads the entry memory and
// holds the request for the evaluation stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cce_front (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     accept,
   input  cce_pkg::req_type        req,
   output cce_pkg::stage_type      stage,
   output cce_pkg::entry_type      entry,
   output cce_pkg::flag_load_type  flag_load
);

   cce_pkg::entry_type             entry_mem_ff [cce_pkg::ENTRY_COUNT];
   cce_pkg::entry_type             rd_entry_ff;
   cce_pkg::stage_type             stage_ff;
   cce_pkg::stage_type             stage_in;
   cce_pkg::entry_type             wr_entry;
   logic [cce_pkg::SLOT_W-1:0]     slot;
   logic                           in_range;
   logic                           misaligned;
   logic                           value_fits;
   logic                           compare_fits;
   logic                           load_ok;
   logic                           load_wr;

   assign slot     = cce_pkg::SLOT_W'(req.index);
   assign in_range = (int'(req.index) < cce_pkg::ENTRY_COUNT);

   // Check alignment and range of a new entry
   always_comb begin
      misaligned = 1'b0;
      case (req.width_code)
         cce_pkg::WIDTH_HALF: misaligned = req.address[0];
         cce_pkg::WIDTH_WORD: misaligned = (req.address[1:0] != 2'b00);
         default:             misaligned = 1'b0;
      endcase
      value_fits   = ((req.value & ~cce_pkg::width_mask(req.width_code)) == 32'd0);
      compare_fits = ((req.compare_value & ~cce_pkg::width_mask(req.width_code)) == 32'd0);
      load_ok      = (cce_pkg::width_bytes(req.width_code) != 3'd0) && !misaligned &&
                     value_fits && (!req.has_compare || compare_fits);
   end

   assign load_wr = accept && (cce_pkg::op_type'(req.op) == cce_pkg::OP_LOAD) &&
                    in_range && load_ok;

   always_comb begin
      wr_entry.once          = req.once;
      wr_entry.width_code    = req.width_code;
      wr_entry.address       = req.address;
      wr_entry.value         = req.value;
      wr_entry.has_compare   = req.has_compare;
      wr_entry.compare_value = req.compare_value;
   end

   // Write a checked load, read the addressed entry for the next stage
   always_ff @(posedge clock) begin
      if (load_wr) begin
         entry_mem_ff[slot] <= wr_entry;
      end
      if (accept) begin
         rd_entry_ff <= entry_mem_ff[slot];
      end
   end

   always_comb begin
      stage_in.valid     = accept;
      stage_in.op        = cce_pkg::op_type'(req.op);
      stage_in.index     = req.index;
      stage_in.in_range  = in_range;
      stage_in.load_ok   = load_ok;
      stage_in.read_data = req.read_data;
      stage_in.read_ok   = req.read_ok;
      stage_in.write_ok  = req.write_ok;
   end

   // Hold the request; only the valid bit needs a reset
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      if (accept) begin
         stage_ff.op        <= stage_in.op;
         stage_ff.index     <= stage_in.index;
         stage_ff.in_range  <= stage_in.in_range;
         stage_ff.load_ok   <= stage_in.load_ok;
         stage_ff.read_data <= stage_in.read_data;
         stage_ff.read_ok   <= stage_in.read_ok;
         stage_ff.write_ok  <= stage_in.write_ok;
      end
   end

   assign stage = stage_ff;
   assign entry = rd_entry_ff;

   always_comb begin
      flag_load.valid   = load_wr;
      flag_load.slot    = slot;
      flag_load.enabled = req.enabled;
   end

endmodule

`default_nettype wire

>>> rtl/core/cce_stats.sv
// ----------------------------------------------------------------------------
// cce_stats
// Eight wrapping 32-bit statistic counters with clear and one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cce_stats (
   input  wire                              clock,
   input  wire                              reset,
   input  cce_pkg::stat_event_type          stat_event,
   input  wire [cce_pkg::CNT_SEL_W-1:0]     rd_sel,
   output logic [31:0]                      rd_value
);

   logic [31:0] counter_ff [cce_pkg::CNT_COUNT];

   // Advance each counter on its own event, drop all on clear
   always_ff @(posedge clock) begin
      if (reset || stat_event.clear) begin
         for (int k = 0; k < cce_pkg::CNT_COUNT; k++) begin
            counter_ff[k] <= 32'd0;
         end
      end else begin
         for (int k = 0; k < cce_pkg::CNT_COUNT; k++) begin
            if (stat_event.inc[k]) begin
               counter_ff[k] <= counter_ff[k] + 32'd1;
            end
         end
      end
   end

   assign rd_value = counter_ff[rd_sel];

endmodule

`default_nettype wire

>>> rtl/core/cce_eval.sv
// ----------------------------------------------------------------------------
// cce_eval
// Evaluation stage: holds the enable and applied-once flags, decides the
// outcome of each request and registers the response.
// ----------------------------------------------------------------------------
`default_nettype none

module cce_eval (
   input  wire                              clock,
   input  wire                              reset,
   input  cce_pkg::stage_type               stage,
   input  cce_pkg::entry_type               entry,
   input  cce_pkg::flag_load_type           flag_load,
   input  wire [31:0]                       cnt_value,
   output logic [cce_pkg::CNT_SEL_W-1:0]    cnt_sel,
   output cce_pkg::stat_event_type          stat_event,
   output logic                             rsp_strobe,
   output cce_pkg::rsp_type                 rsp_payload
);

   logic [cce_pkg::ENTRY_COUNT-1:0]  enable_ff;
   logic [cce_pkg::ENTRY_COUNT-1:0]  once_done_ff;
   cce_pkg::rsp_type                 rsp_ff;
   cce_pkg::rsp_type                 rsp_in;
   logic                             rsp_valid_ff;
   logic [cce_pkg::SLOT_W-1:0]       slot;
   logic [31:0]                      mask;
   logic                             set_once;

   assign slot    = cce_pkg::SLOT_W'(stage.index);
   assign cnt_sel = stage.index[cce_pkg::CNT_SEL_W-1:0];
   assign mask    = cce_pkg::width_mask(entry.width_code);

   // Decide outcome, write request and counter events
   always_comb begin
      rsp_in           = '0;
      rsp_in.outcome   = cce_pkg::OUT_OTHER;
      stat_event       = '0;
      set_once         = 1'b0;
      if (stage.valid) begin
         case (stage.op)
            cce_pkg::OP_LOAD: begin
               if (stage.in_range) begin
                  rsp_in.outcome = stage.load_ok ? cce_pkg::OUT_LOADED
                                                 : cce_pkg::OUT_REJECTED;
               end
            end
            cce_pkg::OP_APPLY: begin
               if (stage.in_range) begin
                  if (!enable_ff[slot]) begin
                     stat_event.inc[cce_pkg::CNT_DISABLED] = 1'b1;
                     rsp_in.outcome = cce_pkg::OUT_DISABLED;
                  end else if (entry.once && once_done_ff[slot]) begin
                     stat_event.inc[cce_pkg::CNT_ONCE] = 1'b1;
                     rsp_in.outcome = cce_pkg::OUT_ONCE_DONE;
                  end else begin
                     stat_event.inc[cce_pkg::CNT_ATTEMPT] = 1'b1;
                     if (entry.has_compare && !stage.read_ok) begin
                        stat_event.inc[cce_pkg::CNT_READFAIL] = 1'b1;
                        rsp_in.outcome = cce_pkg::OUT_READ_FAIL;
                     end else if (entry.has_compare &&
                                  ((stage.read_data & mask) != entry.compare_value)) begin
                        stat_event.inc[cce_pkg::CNT_CMPMISS] = 1'b1;
                        rsp_in.outcome = cce_pkg::OUT_CMP_MISS;
                     end else begin
                        rsp_in.write_request = 1'b1;
                        rsp_in.write_address = entry.address;
                        rsp_in.write_data    = entry.value & mask;
                        rsp_in.write_size    = cce_pkg::width_bytes(entry.width_code);
                        if (!stage.write_ok) begin
                           stat_event.inc[cce_pkg::CNT_WRFAIL] = 1'b1;
                           rsp_in.outcome = cce_pkg::OUT_WR_FAIL;
                        end else begin
                           if (entry.once) begin
                              set_once = 1'b1;
                              stat_event.inc[cce_pkg::CNT_APONCE] = 1'b1;
                           end
                           stat_event.inc[cce_pkg::CNT_APPLIED] = 1'b1;
                           rsp_in.outcome = cce_pkg::OUT_APPLIED;
                        end
                     end
                  end
               end
            end
            cce_pkg::OP_READ_CNT: begin
               if (stage.index[5:cce_pkg::CNT_SEL_W] == '0) begin
                  rsp_in.counter_value = cnt_value;
               end
            end
            cce_pkg::OP_CLEAR_CNT: begin
               stat_event.clear = 1'b1;
            end
            default: begin
               rsp_in.outcome = cce_pkg::OUT_OTHER;
            end
         endcase
      end
   end

   // Update flags; a newer load overrides an older apply on the same slot
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= '0;
         once_done_ff <= '0;
      end else begin
         if (set_once) begin
            once_done_ff[slot] <= 1'b1;
         end
         if (flag_load.valid) begin
            enable_ff[flag_load.slot]    <= flag_load.enabled;
            once_done_ff[flag_load.slot] <= 1'b0;
         end
      end
   end

   // Register the response
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= stage.valid;
      end
      if (stage.valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Every held request produces exactly one response strobe
   a_one_rsp_per_req: assert property (@(posedge clock) disable iff (reset)
      stage.valid |=> rsp_valid_ff)
      else $error("request held in stage produced no response");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      !stage.valid |=> !rsp_valid_ff)
      else $error("response strobe without a request");

   // A write request only comes with an applied or write-failed outcome
   a_write_outcome: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.write_request) |->
         (rsp_ff.outcome == cce_pkg::OUT_APPLIED || rsp_ff.outcome == cce_pkg::OUT_WR_FAIL))
      else $error("write request with wrong outcome");

   // Setting the applied-once mark requires an enabled entry
   a_once_needs_enable: assert property (@(posedge clock) disable iff (reset)
      set_once |-> enable_ff[slot])
      else $error("applied-once mark set on a disabled entry");

endmodule

`default_nettype wire

>>> rtl/core/cheat_compare_write_engine_top.sv
// ----------------------------------------------------------------------------
// cheat_compare_write_engine_top
// Cheat entry table with compare-and-write evaluation and outcome statistics.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low. Its
//   fields arrive in req_payload: load entry, apply entry, read counter or
//   clear counters.
//   Each request gives exactly one response: rsp_strobe is high for one cycle
//   with rsp_payload valid. The request is held in the front stage register,
//   together with the entry memory read, and the response is then registered
//   in the evaluation stage.
//   Throughput is one request per cycle; busy is held low, since the entry
//   memory read and the flag and counter updates never stall, and later
//   requests always see the effects of earlier ones.
//   The receiver cannot stall: a response must be taken in its strobe cycle.
//   Reset clears the enable and applied-once flags and all eight counters;
//   the entry memory itself is not cleared, a slot reads as disabled until a
//   load stores it. No clearing pass is run, requests are taken right after
//   reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cheat_compare_write_engine_top (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   input  cce_pkg::req_type    req_payload,
   output logic                rsp_strobe,
   output cce_pkg::rsp_type    rsp_payload
);

   logic                                 accept;
   cce_pkg::stage_type                   stage;
   cce_pkg::entry_type                   entry;
   cce_pkg::flag_load_type               flag_load;
   cce_pkg::stat_event_type              stat_event;
   logic [cce_pkg::CNT_SEL_W-1:0]        cnt_sel;
   logic [31:0]                          cnt_value;

   // Take a request every cycle
   assign busy   = 1'b0;
   assign accept = start && !busy;

   cce_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_payload),
      .stage     (stage),
      .entry     (entry),
      .flag_load (flag_load)
   );

   cce_stats u_stats (
      .clock      (clock),
      .reset      (reset),
      .stat_event (stat_event),
      .rd_sel     (cnt_sel),
      .rd_value   (cnt_value)
   );

   cce_eval u_eval (
      .clock       (clock),
      .reset       (reset),
      .stage       (stage),
      .entry       (entry),
      .flag_load   (flag_load),
      .cnt_value   (cnt_value),
      .cnt_sel     (cnt_sel),
      .stat_event  (stat_event),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
